// ----- sv/arpool_pkg.sv -----
// ----------------------------------------------------------------------------
// arpool_pkg
// Shared types and constants of the arena pool bump allocator.
// ----------------------------------------------------------------------------
package arpool_pkg;

    localparam int MAX_ARENAS_DEF  = 16;
    localparam int OFFSET_BITS_DEF = 21;

    localparam int CMD_W       = 2;
    localparam int INDEX_W     = 4;
    localparam int BYTES_W     = 21;
    localparam int ALIGN_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int FREE_W      = 5;
    localparam int TOTAL_W     = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 21;

    localparam int TOTAL_RST = 16;
    localparam int BYTES_RST = 65536;

    localparam logic [CMD_W-1:0] CMD_GET     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;

    localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] RSP_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] RSP_IGNORED = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ARENA_TOTAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARENA_BYTES = 1'd1;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] arena_index;
        logic [BYTES_W-1:0] request_bytes;
        logic [ALIGN_W-1:0] align_log2;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_arena;
        logic [BYTES_W-1:0]  block_offset;
        logic [FREE_W-1:0]   free_arenas;
    } t_rsp;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_dp_cmd;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

// ----- sv/arpool_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpool_ctrl
// Request sequencing: latch a request, execute it, hand the result to the
// output register.
// ----------------------------------------------------------------------------
module arpool_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output arpool_pkg::t_dp_cmd o_cmd
);

    arpool_pkg::t_state r_state;
    arpool_pkg::t_state n_state;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               w_commit;

    always_comb begin
        n_state = r_state;
        case (r_state)
            arpool_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = arpool_pkg::S_EXEC;
                end
            end
            arpool_pkg::S_EXEC: begin
                if (w_commit) begin
                    n_state = arpool_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arpool_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall     = 1'b1;
        o_cmd.capture  = 1'b0;
        w_commit       = 1'b0;
        case (r_state)
            arpool_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            arpool_pkg::S_EXEC: begin
                w_commit = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
        o_cmd.commit = w_commit;
    end

    always_comb begin
        if (w_commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpool_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/arpool_dp.sv -----
// ----------------------------------------------------------------------------
// arpool_dp
// Pool datapath: claim bits, free count, offset memory with valid bits,
// free-arena search, align/add/compare and the result register.
// ----------------------------------------------------------------------------
module arpool_dp #(
    parameter int MAX_ARENAS  = arpool_pkg::MAX_ARENAS_DEF,
    parameter int OFFSET_BITS = arpool_pkg::OFFSET_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [arpool_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [arpool_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  arpool_pkg::t_dp_cmd                 i_cmd,
    input  arpool_pkg::t_req                    i_req,
    output arpool_pkg::t_rsp                    o_rsp
);

    localparam int GW  = arpool_pkg::INDEX_W;
    localparam int BW  = arpool_pkg::BYTES_W;
    localparam int TW  = arpool_pkg::TOTAL_W;
    localparam int OW  = arpool_pkg::FREE_W;
    localparam int IW  = (MAX_ARENAS > 1) ? $clog2(MAX_ARENAS) : 1;
    localparam int FW  = $clog2(MAX_ARENAS + 1);
    localparam int CW  = (FW > GW) ? FW : GW;
    localparam int AW  = ((OFFSET_BITS > BW) ? OFFSET_BITS : BW) + 1;
    localparam int EW  = AW + 1;
    localparam int CNT_RST = (MAX_ARENAS < arpool_pkg::TOTAL_RST) ?
                             MAX_ARENAS : arpool_pkg::TOTAL_RST;
    localparam longint OFF_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam longint CAP_RST = (longint'(arpool_pkg::BYTES_RST) > OFF_MAX) ?
                                 OFF_MAX : longint'(arpool_pkg::BYTES_RST);

    logic [FW-1:0]          r_cnt;
    logic [AW-1:0]          r_cap;
    logic [MAX_ARENAS-1:0]  r_claim;
    logic [MAX_ARENAS-1:0]  n_claim;
    logic [MAX_ARENAS-1:0]  r_live;
    logic [MAX_ARENAS-1:0]  n_live;
    logic [FW-1:0]          r_free;
    logic [FW-1:0]          n_free;
    logic [OFFSET_BITS-1:0] r_mem [MAX_ARENAS];
    logic [OFFSET_BITS-1:0] r_rd_data;
    logic                   r_rd_live;
    arpool_pkg::t_req       r_req;
    logic [AW-1:0]          r_mask;
    arpool_pkg::t_rsp       r_rsp;
    arpool_pkg::t_rsp       n_rsp;

    logic [FW-1:0]          w_cfg_cnt;
    logic [AW-1:0]          w_cfg_cap;
    logic [TW-1:0]          w_cfg_total;
    logic [AW-1:0]          w_cfg_bytes;
    logic [IW-1:0]          w_ix;
    logic                   w_in_range;
    logic [AW-1:0]          w_off;
    logic [AW-1:0]          w_aligned;
    logic [EW-1:0]          w_end;
    logic                   w_fits;
    logic                   w_found;
    logic [IW-1:0]          w_get_idx;
    logic                   w_mem_we;

    // effective register values
    always_comb begin
        w_cfg_total = i_cfg_data[TW-1:0];
        w_cfg_bytes = AW'(i_cfg_data[BW-1:0]);
        if (int'(w_cfg_total) > MAX_ARENAS) begin
            w_cfg_cnt = FW'(MAX_ARENAS);
        end else begin
            w_cfg_cnt = FW'(w_cfg_total);
        end
        if (w_cfg_bytes > AW'(OFF_MAX)) begin
            w_cfg_cap = AW'(OFF_MAX);
        end else begin
            w_cfg_cap = w_cfg_bytes;
        end
    end

    // lowest unclaimed arena below the count
    always_comb begin
        w_found   = 1'b0;
        w_get_idx = '0;
        for (int i = MAX_ARENAS - 1; i >= 0; i--) begin
            if (!r_claim[i] && (i < int'(r_cnt))) begin
                w_found   = 1'b1;
                w_get_idx = IW'(i);
            end
        end
    end

    always_comb begin
        w_ix       = IW'(r_req.arena_index);
        w_in_range = CW'(r_req.arena_index) < CW'(r_cnt);
        w_off      = r_rd_live ? AW'(r_rd_data) : '0;
        w_aligned  = (w_off + r_mask) & ~r_mask;
        w_end      = EW'(w_aligned) + EW'(r_req.request_bytes);
        w_fits     = w_end <= EW'(r_cap);
    end

    always_comb begin
        n_claim                = r_claim;
        n_live                 = r_live;
        n_free                 = r_free;
        w_mem_we               = 1'b0;
        n_rsp.status           = arpool_pkg::RSP_IGNORED;
        n_rsp.granted_arena    = r_req.arena_index;
        n_rsp.block_offset     = '0;
        case (r_req.command)
            arpool_pkg::CMD_GET: begin
                n_rsp.status        = arpool_pkg::RSP_FAIL;
                n_rsp.granted_arena = '0;
                if (w_found) begin
                    n_claim[w_get_idx]  = 1'b1;
                    n_rsp.status        = arpool_pkg::RSP_OK;
                    n_rsp.granted_arena = GW'(w_get_idx);
                    if (r_free != '0) begin
                        n_free = r_free - FW'(1);
                    end
                end
            end
            arpool_pkg::CMD_RELEASE: begin
                if (w_in_range && r_claim[w_ix]) begin
                    n_claim[w_ix] = 1'b0;
                    n_live[w_ix]  = 1'b0;
                    n_free        = r_free + FW'(1);
                    n_rsp.status  = arpool_pkg::RSP_OK;
                end
            end
            arpool_pkg::CMD_ALLOC: begin
                n_rsp.status = arpool_pkg::RSP_FAIL;
                if (w_in_range && w_fits) begin
                    w_mem_we           = 1'b1;
                    n_live[w_ix]       = 1'b1;
                    n_rsp.status       = arpool_pkg::RSP_OK;
                    n_rsp.block_offset = BW'(w_aligned);
                end
            end
            default: begin
                n_rsp.status = arpool_pkg::RSP_IGNORED;
            end
        endcase
        n_rsp.free_arenas = OW'(n_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= FW'(CNT_RST);
            r_cap   <= AW'(CAP_RST);
            r_claim <= '0;
            r_live  <= '0;
            r_free  <= FW'(CNT_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arpool_pkg::CFG_ARENA_TOTAL: begin
                    r_cnt  <= w_cfg_cnt;
                    r_free <= w_cfg_cnt;
                end
                arpool_pkg::CFG_ARENA_BYTES: begin
                    r_cap  <= w_cfg_cap;
                    r_free <= r_cnt;
                end
                default: begin
                    r_free <= r_cnt;
                end
            endcase
            r_claim <= '0;
            r_live  <= '0;
        end else if (i_cmd.commit) begin
            r_claim <= n_claim;
            r_live  <= n_live;
            r_free  <= n_free;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && w_mem_we && !i_cfg_we) begin
            r_mem[w_ix] <= OFFSET_BITS'(w_end);
        end
        if (i_cmd.capture) begin
            r_rd_data <= r_mem[IW'(i_req.arena_index)];
            r_rd_live <= r_live[IW'(i_req.arena_index)];
            r_req     <= i_req;
            r_mask    <= ~({AW{1'b1}} << i_req.align_log2);
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    a_free_matches_claims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_free) + $countones(r_claim) == int'(r_cnt))
        else $error("free count disagrees with claim bits");

    a_claims_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_claim >> r_cnt) == '0)
        else $error("claim bit set beyond arena count");

    a_get_sets_claim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !i_cfg_we && r_req.command == arpool_pkg::CMD_GET && w_found)
        |=> r_claim[$past(w_get_idx)])
        else $error("granted arena not marked claimed");

endmodule

// ----- sv/arena_pool_bump_allocator.sv -----
// ----------------------------------------------------------------------------
// arena_pool_bump_allocator
// Pool of arenas with claim/release and bump allocation inside an arena.
//
//   channel   valid        stall         payload
//   request   i_in_valid   o_in_stall    i_in_req  (arpool_pkg::t_req)
//   result    o_out_valid  i_out_stall   o_out_rsp (arpool_pkg::t_rsp)
//   config    i_cfg_we     -             i_cfg_index, i_cfg_data
//
// A request is latched in S_IDLE, which also reads its arena offset from the
// offset memory; S_EXEC runs the free-arena search or the align, add and
// capacity compare and writes the result register.
// A result waiting under i_out_stall holds the next request in execution.
// Synchronous active-low reset; offsets clear through per-arena valid bits,
// so no clearing pass. A config write rebuilds the pool.
// ----------------------------------------------------------------------------
module arena_pool_bump_allocator #(
    parameter int MAX_ARENAS  = arpool_pkg::MAX_ARENAS_DEF,
    parameter int OFFSET_BITS = arpool_pkg::OFFSET_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [arpool_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [arpool_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  arpool_pkg::t_req                   i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output arpool_pkg::t_rsp                   o_out_rsp
);

    arpool_pkg::t_dp_cmd w_cmd;

    arpool_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    arpool_dp #(
        .MAX_ARENAS  (MAX_ARENAS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .i_req       (i_in_req),
        .o_rsp       (o_out_rsp)
    );

endmodule
